>>> design/rtoc_pkg.sv
// Package: shared types and constants for the relay/triac output controller.
`default_nettype none
package rtoc_pkg;
	localparam int NumOutputsDef  = 16;
	localparam int NumChannelsDef = 4;
	localparam int NumButtonsDef  = 5;
	localparam int CfgIdxW        = 3;
	localparam logic [8:0] PulseRelay = 9'h100;
	localparam logic [7:0] RelayBits  = 8'h55;
	localparam logic [6:0] MsPerTenth = 7'd100;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_WRITE  = 3'd1,
		ACT_SET    = 3'd2,
		ACT_TOGGLE = 3'd3,
		ACT_DELAY  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		WM_SET    = 2'd0,
		WM_CLEAR  = 2'd1,
		WM_TOGGLE = 2'd2
	} write_mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TRIACS_DISABLED = 3'd0,
		CFG_ENABLE          = 3'd1,
		CFG_ANTICHATTER     = 3'd2,
		CFG_LONG_PRESS      = 3'd3,
		CFG_PULSE           = 3'd4,
		CFG_TRIAC_PHASE     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic        triacs_disabled;
		logic        controller_enable;
		logic [15:0] antichatter_ms;
		logic [15:0] long_press_ms;
		logic [15:0] pulse_ms;
		logic [15:0] triac_phase_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] now_ms;
		logic [4:0]  button_pins;
		logic [1:0]  write_mode;
		logic [15:0] write_mask;
		logic [3:0]  channel;
		logic        channel_value;
		logic [15:0] delay_tenths;
	} item_t;
endpackage
`default_nettype wire

>>> design/rtoc_if.sv
// Interfaces: item, result and configuration channels.
`default_nettype none
interface rtoc_item_if import rtoc_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtoc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] output_bits;
	modport source (output valid, output output_bits, input ready);
	modport sink (input valid, input output_bits, output ready);
endinterface

interface rtoc_cfg_if import rtoc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [15:0]        wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> design/rtoc_cfg.sv
// Configuration register file.
`default_nettype none
module rtoc_cfg import rtoc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rtoc_cfg_if.sink  cfg,
	output cfg_t      regs
);
	cfg_t regs_q;
	assign cfg.ready = 1'b1;
	assign regs = regs_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{1'b0, 1'b1, 16'd200, 16'd3000, 16'd500, 16'd100};
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_TRIACS_DISABLED: regs_q.triacs_disabled   <= cfg.wdata[0];
				CFG_ENABLE:          regs_q.controller_enable <= cfg.wdata[0];
				CFG_ANTICHATTER:     regs_q.antichatter_ms    <= cfg.wdata;
				CFG_LONG_PRESS:      regs_q.long_press_ms     <= cfg.wdata;
				CFG_PULSE:           regs_q.pulse_ms          <= cfg.wdata;
				CFG_TRIAC_PHASE:     regs_q.triac_phase_ms    <= cfg.wdata;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/relay_triac_output_controller.sv
// Top level: relay/triac output controller.
//  channel | dir | payload
//  in      | in  | item_t (action, now_ms, pins, write fields, channel, delay)
//  out     | out | output_bits
//  cfg     | in  | index, wdata
// One item per cycle unless the output stalls; each item's result is registered on accept.
// Timer logic for all channels, outputs and buttons runs in one pass on the state registers.
// arst_n clears the output register, all timers and sets last buttons to all ones.
// Input ready follows output ready or an empty result register.
`default_nettype none
module relay_triac_output_controller import rtoc_pkg::*; #(
	parameter int NUM_OUTPUTS  = NumOutputsDef,
	parameter int NUM_CHANNELS = NumChannelsDef,
	parameter int NUM_BUTTONS  = NumButtonsDef
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rtoc_item_if.sink   in,
	rtoc_result_if.source out,
	rtoc_cfg_if.sink    cfg
);
	cfg_t cr;
	rtoc_cfg u_cfg (.clk(clk), .arst_n(arst_n), .cfg(cfg), .regs(cr));

	logic [15:0] out_q;
	logic        ovalid_q;
	logic [31:0] ton_q [NUM_CHANNELS];
	logic [31:0] toff_q [NUM_CHANNELS];
	logic [31:0] pulse_q;
	logic [31:0] aos_q [NUM_OUTPUTS];
	logic [15:0] aod_q [NUM_OUTPUTS];
	logic [31:0] press_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] last_q;

	logic [15:0] res_d;
	logic [31:0] ton_d [NUM_CHANNELS];
	logic [31:0] toff_d [NUM_CHANNELS];
	logic [31:0] pulse_d;
	logic [31:0] aos_d [NUM_OUTPUTS];
	logic [31:0] press_d [NUM_BUTTONS];
	logic [15:0] omask;
	logic        acc;
	item_t       it;

	assign omask = 16'((17'd1 << NUM_OUTPUTS) - 17'd1);
	assign it = in.data;
	assign in.ready = !ovalid_q || out.ready;
	assign acc = in.valid && in.ready;
	assign out.valid = ovalid_q;
	assign out.output_bits = out_q;

	always_comb begin
		logic [15:0] r, snap, live;
		logic [31:0] d, lim;
		logic [NUM_BUTTONS-1:0] chg;
		r = out_q;
		snap = out_q;
		live = '0;
		d = '0;
		lim = '0;
		chg = last_q ^ it.button_pins[NUM_BUTTONS-1:0];
		pulse_d = pulse_q;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			ton_d[c] = ton_q[c];
			toff_d[c] = toff_q[c];
		end
		for (int i = 0; i < NUM_OUTPUTS; i++) aos_d[i] = aos_q[i];
		for (int n = 0; n < NUM_BUTTONS; n++) press_d[n] = press_q[n];
		case (action_t'(it.action))
			ACT_TICK: if (cr.controller_enable) begin
				if (!cr.triacs_disabled) begin
					for (int c = 0; c < NUM_CHANNELS; c++) begin
						if (snap[2*c+1]) begin
							if (ton_q[c] == '0 && toff_q[c] == '0) begin
								ton_d[c] = it.now_ms;
							end else if (ton_q[c] != '0 &&
								it.now_ms - ton_q[c] > {16'd0, cr.triac_phase_ms}) begin
								r[2*c] = !r[2*c];
								ton_d[c] = '0;
								toff_d[c] = it.now_ms;
							end else if (ton_q[c] == '0 &&
								it.now_ms - toff_q[c] > {16'd0, cr.triac_phase_ms}) begin
								r[2*c+1] = 1'b0;
								toff_d[c] = '0;
							end
						end
					end
				end
				if (pulse_d == '0 && snap[8]) pulse_d = it.now_ms;
				if (pulse_d != '0 && it.now_ms - pulse_d > {16'd0, cr.pulse_ms}) begin
					r[8] = 1'b0;
					pulse_d = '0;
				end
				for (int i = 0; i < NUM_OUTPUTS; i++) begin
					if (aod_q[i] != '0) begin
						lim = 32'(aod_q[i]) * 32'(MsPerTenth);
						if (!snap[i]) aos_d[i] = '0;
						else if (aos_q[i] == '0) aos_d[i] = it.now_ms;
						if (snap[i] && aos_d[i] != '0 && it.now_ms - aos_d[i] > lim) begin
							r[i] = 1'b0;
							aos_d[i] = '0;
						end
					end
				end
				for (int n = 0; n < NUM_BUTTONS; n++) begin
					d = it.now_ms - press_d[n];
					if (d > {16'd0, cr.antichatter_ms} && chg[n]) begin
						if (it.button_pins[n]) begin
							if (n > 3 || d > {16'd0, cr.long_press_ms}) begin
								live = r;
								if (cr.triacs_disabled) begin
									r[7:0] = 8'h00;
								end else begin
									for (int c = 0; c < NUM_CHANNELS; c++) begin
										if (live[2*c]) begin
											r[2*c+1] = 1'b1;
											ton_d[c] = it.now_ms;
										end
									end
								end
								if (n < 4) r = r | 16'(PulseRelay);
								pulse_d = it.now_ms;
							end else begin
								for (int c = 0; c < NUM_CHANNELS; c++) begin
									if (c == n) begin
										if (cr.triacs_disabled) r[2*c] = !r[2*c];
										else begin
											r[2*c+1] = 1'b1;
											ton_d[c] = it.now_ms;
										end
									end
								end
							end
						end
						press_d[n] = it.now_ms;
					end
				end
			end
			ACT_WRITE: begin
				case (write_mode_t'(it.write_mode))
					WM_SET:    r = r | it.write_mask;
					WM_CLEAR:  r = r & ~it.write_mask;
					WM_TOGGLE: r = r ^ it.write_mask;
					default: ;
				endcase
			end
			ACT_SET, ACT_TOGGLE: begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (it.channel == 4'(c)) begin
						if (cr.triacs_disabled) begin
							if (it.action == ACT_TOGGLE) r[2*c] = !r[2*c];
							else r[2*c] = it.channel_value;
						end else if (it.action == ACT_TOGGLE ||
							r[2*c] != it.channel_value) begin
							r[2*c+1] = 1'b1;
							ton_d[c] = it.now_ms;
						end
					end
				end
			end
			default: ;
		endcase
		res_d = r & omask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
			ovalid_q <= 1'b0;
			pulse_q <= '0;
			last_q <= '1;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				ton_q[c] <= '0;
				toff_q[c] <= '0;
			end
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				aos_q[i] <= '0;
				aod_q[i] <= '0;
			end
			for (int n = 0; n < NUM_BUTTONS; n++) press_q[n] <= '0;
		end else begin
			ovalid_q <= acc || (ovalid_q && !out.ready);
			if (acc) begin
				out_q <= res_d;
				pulse_q <= pulse_d;
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					ton_q[c] <= ton_d[c];
					toff_q[c] <= toff_d[c];
				end
				for (int i = 0; i < NUM_OUTPUTS; i++) aos_q[i] <= aos_d[i];
				for (int n = 0; n < NUM_BUTTONS; n++) press_q[n] <= press_d[n];
				if (it.action == ACT_TICK && cr.controller_enable)
					last_q <= it.button_pins[NUM_BUTTONS-1:0];
				if (it.action == ACT_DELAY && 32'(it.channel) < 32'(NUM_OUTPUTS))
					aod_q[it.channel[$clog2(NUM_OUTPUTS)-1:0]] <= it.delay_tenths;
			end
		end
	end

	a_out_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_q & ~omask) == '0) else $error("output bits beyond range");
	a_valid_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ovalid_q) else $error("accepted beat lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out.ready |=> $stable(out_q)) else $error("result changed under stall");
endmodule
`default_nettype wire
